// ----- design/flicd_pkg.sv -----
package flicd_pkg;

  localparam int unsigned MaxWidth       = 1024;
  localparam int unsigned MaxHeight      = 1024;
  localparam int unsigned PaletteEntries = 256;
  localparam int unsigned DimW           = 11;
  localparam int unsigned PtrW           = 21;

  localparam logic [15:0] CK_SS2   = 16'd7;
  localparam logic [15:0] CK_PAL8  = 16'd4;
  localparam logic [15:0] CK_PAL6  = 16'd11;
  localparam logic [15:0] CK_BLACK = 16'd13;
  localparam logic [15:0] CK_BRUN  = 16'd15;
  localparam logic [15:0] CK_COPY  = 16'd16;
  localparam logic [15:0] CK_LC    = 16'd120;

  localparam logic [7:0] REG_WIDTH  = 8'd0;
  localparam logic [7:0] REG_HEIGHT = 8'd1;

  typedef enum logic [1:0] {
    WK_BYTE = 2'd0,
    WK_WORD = 2'd1,
    WK_PAL  = 2'd2,
    WK_END  = 2'd3
  } write_kind_e;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic        frame_start;
    logic [15:0] chunk_count;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  write_kind;
    logic [19:0] write_address;
    logic [20:0] run_length;
    logic [15:0] write_value;
    logic        frame_end;
  } out_item_t;

  function automatic logic [DimW-1:0] eff_dim(input logic [DimW-1:0] v,
                                              input logic [DimW-1:0] lim);
    logic [DimW-1:0] r;
    r = v;
    if (v == '0) r = DimW'(1);
    else if (v > lim) r = lim;
    return r;
  endfunction

endpackage

// ----- design/flic_chunk_decoder_unit.sv -----
// FLIC frame chunk decoder.
// Input channel (in_valid_i/in_ready_o/in_data_i): one byte of a frame's chunk
// data per transaction; frame_start flags the first byte and carries the chunk
// count. Output channel (out_valid_o/out_ready_i/out_data_o): pixel byte runs,
// pixel word runs, palette byte writes and the frame end record.
// Config channel (cfg_valid_i/cfg_ready_o/cfg_index_i/cfg_data_i): register 0
// is the frame width, register 1 the frame height; always ready, to be written
// only while idle (not enforced by the block). The frame size product is
// registered on the write itself. Each byte is parsed combinationally from the
// parser registers and its results (at most a write and a frame end) are pushed
// into a 4-entry output queue, so out_valid_o rises in the cycle after the input
// transaction. Throughput: 1 byte per cycle while the queue has room, set by the
// single-pass parser step. When the receiver stalls the queue fills; in_ready_o
// drops once fewer than two entries are free, so no result is lost.
// Reset: parser idle (bytes ignored until a frame start), queue empty,
// width 320, height 200.
module flic_chunk_decoder_unit (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  flicd_pkg::in_item_t   in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output flicd_pkg::out_item_t  out_data_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [7:0]            cfg_index_i,
  input  logic [10:0]           cfg_data_i
);

  localparam int unsigned PW = flicd_pkg::PtrW;
  localparam logic [10:0] MaxW = 11'(flicd_pkg::MaxWidth);
  localparam logic [10:0] MaxH = 11'(flicd_pkg::MaxHeight);
  localparam logic [8:0]  PalN = 9'(flicd_pkg::PaletteEntries);

  typedef enum logic [24:0] {
    PH_IDLE      = 25'h0000001,
    PH_HDR       = 25'h0000002,
    PH_PAD       = 25'h0000004,
    PH_SS2_LINES = 25'h0000008,
    PH_SS2_CTRL  = 25'h0000010,
    PH_SS2_SKIP  = 25'h0000020,
    PH_SS2_CNT   = 25'h0000040,
    PH_SS2_REP   = 25'h0000080,
    PH_SS2_LIT   = 25'h0000100,
    PH_LC_SKIPL  = 25'h0000200,
    PH_LC_LINES  = 25'h0000400,
    PH_LC_PKTS   = 25'h0000800,
    PH_LC_SKIP   = 25'h0001000,
    PH_LC_CNT    = 25'h0002000,
    PH_LC_REP    = 25'h0004000,
    PH_LC_LIT    = 25'h0008000,
    PH_BR_PKTS   = 25'h0010000,
    PH_BR_CNT    = 25'h0020000,
    PH_BR_REP    = 25'h0040000,
    PH_BR_LIT    = 25'h0080000,
    PH_COPY      = 25'h0100000,
    PH_PAL_PKTS  = 25'h0200000,
    PH_PAL_SKIP  = 25'h0400000,
    PH_PAL_CNT   = 25'h0800000,
    PH_PAL_DATA  = 25'h1000000
  } phase_e;

  typedef struct packed {
    logic                 valid;
    flicd_pkg::out_item_t rec;
  } wr_t;

  logic [10:0]   width_q, height_q;
  logic [PW-1:0] fsize_q;
  logic [10:0]   effw, effh;

  phase_e        phase_q, phase_d;
  logic [31:0]   cbl_q, cbl_d;
  logic [15:0]   kind_q, kind_d;
  logic [15:0]   cl_q, cl_d;
  logic [15:0]   ll_q, ll_d;
  logic [15:0]   pl_q, pl_d;
  logic [PW-1:0] lb_q, lb_d;
  logic [PW-1:0] wp_q, wp_d;
  logic [8:0]    rl_q, rl_d;
  logic [31:0]   fa_q, fa_d;
  logic [8:0]    pi_q, pi_d;
  logic [2:0]    bs_q, bs_d;

  flicd_pkg::out_item_t fifo_q [4];
  logic [1:0] rptr_q, wptr_q;
  logic [2:0] cnt_q;

  wr_t        wr;
  logic       fe;
  logic       in_acc, out_acc;
  logic [7:0] b;
  logic [15:0] w;
  logic       pk_done, ln_done, chunk_over;
  phase_e     pkt_next, line_next;
  logic [26:0] skip_prod;
  logic [9:0]  pi_sum;
  logic [7:0]  pal_val;
  logic [19:0] pal_addr;
  logic [10:0] cfg_w, cfg_h;

  function automatic logic [PW-1:0] ptr_add(input logic [PW-1:0] p, input logic [26:0] d,
                                            input logic [PW-1:0] s);
    logic [27:0] r;
    r = {7'b0, p} + {1'b0, d};
    return (r > {7'b0, s}) ? s : r[PW-1:0];
  endfunction

  function automatic wr_t pixel_run(input flicd_pkg::write_kind_e k, input logic [PW-1:0] a,
                                    input logic [PW-1:0] len, input logic [15:0] v,
                                    input logic [PW-1:0] s);
    wr_t o;
    logic [PW-1:0] room, l;
    o = '0;
    room = s - a;
    if (k == flicd_pkg::WK_WORD) room = room >> 1;
    l = (len > room) ? room : len;
    if (a < s && l != '0) begin
      o.valid             = 1'b1;
      o.rec.write_kind    = k;
      o.rec.write_address = a[19:0];
      o.rec.run_length    = l;
      o.rec.write_value   = v;
      o.rec.frame_end     = 1'b0;
    end
    return o;
  endfunction

  assign effw = flicd_pkg::eff_dim(width_q, MaxW);
  assign effh = flicd_pkg::eff_dim(height_q, MaxH);
  assign cfg_ready_o = 1'b1;
  assign cfg_w = (cfg_index_i == flicd_pkg::REG_WIDTH) ? flicd_pkg::eff_dim(cfg_data_i, MaxW)
                                                       : effw;
  assign cfg_h = (cfg_index_i == flicd_pkg::REG_HEIGHT) ? flicd_pkg::eff_dim(cfg_data_i, MaxH)
                                                        : effh;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= 11'd320;
      height_q <= 11'd200;
      fsize_q  <= PW'(64000);
    end else if (cfg_valid_i) begin
      if (cfg_index_i == flicd_pkg::REG_WIDTH) width_q <= cfg_data_i;
      if (cfg_index_i == flicd_pkg::REG_HEIGHT) height_q <= cfg_data_i;
      if (cfg_index_i == flicd_pkg::REG_WIDTH || cfg_index_i == flicd_pkg::REG_HEIGHT) begin
        fsize_q <= PW'({10'b0, cfg_w} * {10'b0, cfg_h});
      end
    end
  end

  assign in_ready_o  = (cnt_q <= 3'd2);
  assign in_acc      = in_valid_i && in_ready_o;
  assign out_valid_o = (cnt_q != 3'd0);
  assign out_acc     = out_valid_o && out_ready_i;
  assign out_data_o  = fifo_q[rptr_q];
  assign b           = in_data_i.data_byte;
  assign w           = {b, fa_q[7:0]};
  // word delta skips count back from 65536; the line delta skip is a plain count
  assign skip_prod   = (w[15] && phase_q == PH_SS2_CTRL)
                         ? 27'({16'b0, effw} * {11'b0, 16'(17'h10000 - {1'b0, w})})
                         : 27'({16'b0, effw} * {11'b0, w});
  assign pi_sum      = {1'b0, pi_q} + {2'b0, b};
  assign pal_val     = (kind_q == flicd_pkg::CK_PAL6) ? {b[5:0], 2'b00} : b;
  assign pal_addr    = {11'b0, pi_q} + {10'b0, pi_q[8:0], 1'b0} + {17'b0, bs_q};

  always_comb begin
    phase_d = phase_q; cbl_d = cbl_q; kind_d = kind_q; cl_d = cl_q;
    ll_d = ll_q; pl_d = pl_q; lb_d = lb_q; wp_d = wp_q; rl_d = rl_q;
    fa_d = fa_q; pi_d = pi_q; bs_d = bs_q;
    wr = '0; fe = 1'b0;
    pk_done = 1'b0; ln_done = 1'b0; chunk_over = 1'b0;
    pkt_next = PH_PAD; line_next = PH_PAD;
    if (in_data_i.frame_start) begin
      cl_d = in_data_i.chunk_count;
      phase_d = PH_HDR;
      bs_d = '0;
      fa_d = '0;
      if (in_data_i.chunk_count == '0) begin
        phase_d = PH_IDLE;
        fe = 1'b1;
      end
    end
    if (!fe && phase_d == PH_HDR) begin
      unique case (bs_d)
        3'd0:    fa_d = {24'b0, b};
        3'd1:    fa_d[15:8] = b;
        3'd2:    fa_d[23:16] = b;
        3'd3:    fa_d[31:24] = b;
        3'd4:    kind_d = {8'b0, b};
        default: kind_d = {b, kind_d[7:0]};
      endcase
      bs_d = bs_d + 3'd1;
      if (bs_d == 3'd6) begin
        bs_d = '0; wp_d = '0; lb_d = '0; ll_d = '0; pl_d = '0; rl_d = '0;
        priority case (kind_d)
          flicd_pkg::CK_SS2:  phase_d = PH_SS2_LINES;
          flicd_pkg::CK_LC:   phase_d = PH_LC_SKIPL;
          flicd_pkg::CK_BRUN: begin
            ll_d = {5'b0, effh};
            phase_d = PH_BR_PKTS;
          end
          flicd_pkg::CK_COPY: phase_d = PH_COPY;
          flicd_pkg::CK_BLACK: begin
            wr = pixel_run(flicd_pkg::WK_BYTE, '0, fsize_q, 16'd0, fsize_q);
            phase_d = PH_PAD;
          end
          flicd_pkg::CK_PAL8, flicd_pkg::CK_PAL6: phase_d = PH_PAL_PKTS;
          default: phase_d = PH_PAD;
        endcase
        cbl_d = (fa_d > 32'd6) ? fa_d - 32'd6 : 32'd0;
        chunk_over = (cbl_d == '0);
      end
    end else if (!fe && phase_d != PH_IDLE) begin
      if (cbl_d != '0) cbl_d = cbl_d - 32'd1;
      unique case (phase_d)
        PH_SS2_LINES, PH_LC_LINES: begin
          if (bs_d == '0) begin
            fa_d = {24'b0, b}; bs_d = 3'd1;
          end else begin
            bs_d = '0;
            ll_d = w;
            phase_d = (w == '0) ? PH_PAD : ((phase_q == PH_SS2_LINES) ? PH_SS2_CTRL
                                                                         : PH_LC_PKTS);
          end
        end
        PH_SS2_CTRL: begin
          if (bs_d == '0) begin
            fa_d = {24'b0, b}; bs_d = 3'd1;
          end else begin
            bs_d = '0;
            if (w[15]) begin
              wp_d = ptr_add(wp_q, skip_prod, fsize_q);
            end else begin
              pl_d = (w > {5'b0, effh}) ? 16'd0 : w;
              lb_d = wp_q;
              if (pl_d == '0) begin
                ln_done = 1'b1; line_next = PH_SS2_CTRL;
              end else begin
                phase_d = PH_SS2_SKIP;
              end
            end
          end
        end
        PH_SS2_SKIP, PH_LC_SKIP: begin
          wp_d = ptr_add(wp_q, {19'b0, b}, fsize_q);
          phase_d = (phase_q == PH_SS2_SKIP) ? PH_SS2_CNT : PH_LC_CNT;
        end
        PH_SS2_CNT: begin
          if (b[7]) begin
            rl_d = 9'h100 - {1'b0, b}; phase_d = PH_SS2_REP;
          end else if (b == '0) begin
            pk_done = 1'b1; pkt_next = PH_SS2_SKIP; line_next = PH_SS2_CTRL;
          end else begin
            rl_d = {b, 1'b0}; phase_d = PH_SS2_LIT;
          end
        end
        PH_SS2_REP: begin
          if (bs_d == '0) begin
            fa_d = {24'b0, b}; bs_d = 3'd1;
          end else begin
            bs_d = '0;
            wr = pixel_run(flicd_pkg::WK_WORD, wp_q, {12'b0, rl_q}, w, fsize_q);
            wp_d = ptr_add(wp_q, {17'b0, rl_q, 1'b0}, fsize_q);
            pk_done = 1'b1; pkt_next = PH_SS2_SKIP; line_next = PH_SS2_CTRL;
          end
        end
        PH_SS2_LIT, PH_LC_LIT, PH_BR_LIT: begin
          wr = pixel_run(flicd_pkg::WK_BYTE, wp_q, PW'(1), {8'b0, b}, fsize_q);
          wp_d = ptr_add(wp_q, 27'd1, fsize_q);
          if (rl_d != '0) rl_d = rl_d - 9'd1;
          if (rl_d == '0) begin
            pk_done = 1'b1;
            priority case (phase_q)
              PH_SS2_LIT: begin pkt_next = PH_SS2_SKIP; line_next = PH_SS2_CTRL; end
              PH_LC_LIT:  begin pkt_next = PH_LC_SKIP;  line_next = PH_LC_PKTS;  end
              default:    begin pkt_next = PH_BR_CNT;   line_next = PH_BR_PKTS;  end
            endcase
          end
        end
        PH_LC_SKIPL: begin
          if (bs_d == '0) begin
            fa_d = {24'b0, b}; bs_d = 3'd1;
          end else begin
            bs_d = '0;
            lb_d = ptr_add('0, skip_prod, fsize_q);
            wp_d = lb_d;
            phase_d = PH_LC_LINES;
          end
        end
        PH_LC_PKTS, PH_BR_PKTS: begin
          pl_d = {8'b0, b};
          if (b == '0) begin
            ln_done = 1'b1; line_next = phase_q;
          end else begin
            phase_d = (phase_q == PH_LC_PKTS) ? PH_LC_SKIP : PH_BR_CNT;
          end
        end
        PH_LC_CNT: begin
          if (b[7]) begin
            rl_d = 9'h100 - {1'b0, b}; phase_d = PH_LC_REP;
          end else if (b == '0) begin
            pk_done = 1'b1; pkt_next = PH_LC_SKIP; line_next = PH_LC_PKTS;
          end else begin
            rl_d = {1'b0, b}; phase_d = PH_LC_LIT;
          end
        end
        PH_LC_REP, PH_BR_REP: begin
          wr = pixel_run(flicd_pkg::WK_BYTE, wp_q, {12'b0, rl_q}, {8'b0, b}, fsize_q);
          wp_d = ptr_add(wp_q, {18'b0, rl_q}, fsize_q);
          pk_done = 1'b1;
          if (phase_q == PH_LC_REP) begin
            pkt_next = PH_LC_SKIP; line_next = PH_LC_PKTS;
          end else begin
            pkt_next = PH_BR_CNT; line_next = PH_BR_PKTS;
          end
        end
        PH_BR_CNT: begin
          if (b[7]) begin
            rl_d = 9'h100 - {1'b0, b}; phase_d = PH_BR_LIT;
          end else begin
            rl_d = {1'b0, b}; phase_d = PH_BR_REP;
          end
        end
        PH_COPY: begin
          wr = pixel_run(flicd_pkg::WK_BYTE, wp_q, PW'(1), {8'b0, b}, fsize_q);
          wp_d = ptr_add(wp_q, 27'd1, fsize_q);
          if (wp_d >= fsize_q) phase_d = PH_PAD;
        end
        PH_PAL_PKTS: begin
          if (bs_d == '0) begin
            fa_d = {24'b0, b}; bs_d = 3'd1;
          end else begin
            bs_d = '0;
            pl_d = w;
            pi_d = '0;
            phase_d = (w != '0) ? PH_PAL_SKIP : PH_PAD;
          end
        end
        PH_PAL_SKIP: begin
          pi_d = (pi_sum > {1'b0, PalN}) ? PalN : pi_sum[8:0];
          phase_d = PH_PAL_CNT;
        end
        PH_PAL_CNT: begin
          rl_d = (b != '0) ? {1'b0, b} : 9'h100;
          bs_d = '0;
          phase_d = PH_PAL_DATA;
        end
        PH_PAL_DATA: begin
          if (pi_q < PalN) begin
            wr.valid             = 1'b1;
            wr.rec.write_kind    = flicd_pkg::WK_PAL;
            wr.rec.write_address = pal_addr;
            wr.rec.run_length    = 21'd1;
            wr.rec.write_value   = {8'b0, pal_val};
            wr.rec.frame_end     = 1'b0;
          end
          bs_d = bs_d + 3'd1;
          if (bs_d >= 3'd3) begin
            bs_d = '0;
            if (pi_q < PalN) pi_d = pi_q + 9'd1;
            if (rl_d != '0) rl_d = rl_d - 9'd1;
            if (rl_d == '0) begin
              if (pl_d != '0) pl_d = pl_d - 16'd1;
              phase_d = (pl_d != '0) ? PH_PAL_SKIP : PH_PAD;
            end
          end
        end
        default: ;
      endcase
      if (pk_done) begin
        if (pl_d != '0) pl_d = pl_d - 16'd1;
        if (pl_d == '0) ln_done = 1'b1;
        else phase_d = pkt_next;
      end
      if (ln_done) begin
        lb_d = ptr_add(lb_d, {16'b0, effw}, fsize_q);
        wp_d = lb_d;
        if (ll_d != '0) ll_d = ll_d - 16'd1;
        phase_d = (ll_d == '0) ? PH_PAD : line_next;
      end
      chunk_over = (cbl_d == '0);
    end
    if (chunk_over) begin
      if (cl_d != '0) cl_d = cl_d - 16'd1;
      phase_d = PH_HDR;
      bs_d = '0;
      fa_d = '0;
      if (cl_d == '0) begin
        phase_d = PH_IDLE;
        fe = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      cbl_q <= '0; kind_q <= '0; cl_q <= '0; ll_q <= '0; pl_q <= '0;
      lb_q <= '0; wp_q <= '0; rl_q <= '0; fa_q <= '0; pi_q <= '0; bs_q <= '0;
    end else if (in_acc) begin
      phase_q <= phase_d;
      cbl_q <= cbl_d; kind_q <= kind_d; cl_q <= cl_d; ll_q <= ll_d; pl_q <= pl_d;
      lb_q <= lb_d; wp_q <= wp_d; rl_q <= rl_d; fa_q <= fa_d; pi_q <= pi_d; bs_q <= bs_d;
    end
  end

  localparam flicd_pkg::out_item_t EndRec = '{write_kind: flicd_pkg::WK_END,
                                               write_address: '0, run_length: '0,
                                               write_value: '0, frame_end: 1'b1};

  logic [2:0] n_push;
  assign n_push = in_acc ? ({2'b0, wr.valid} + {2'b0, fe}) : 3'd0;

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      if (wr.valid) begin
        fifo_q[wptr_q] <= wr.rec;
        if (fe) fifo_q[wptr_q + 2'd1] <= EndRec;
      end else if (fe) begin
        fifo_q[wptr_q] <= EndRec;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rptr_q <= '0; wptr_q <= '0; cnt_q <= '0;
    end else begin
      wptr_q <= wptr_q + n_push[1:0];
      if (out_acc) rptr_q <= rptr_q + 2'd1;
      cnt_q <= cnt_q + n_push - {2'b0, out_acc};
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= 3'd4)
    else $error("output queue overflow");
  a_ready_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> cnt_q <= 3'd4 && $past(cnt_q) <= 3'd2)
    else $error("input taken without queue room");
  a_end_rec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.frame_end |->
      out_data_o.write_kind == flicd_pkg::WK_END && out_data_o.run_length == '0)
    else $error("malformed frame end record");

endmodule

// ----- tb/sv/flic_chunk_decoder_unit_tb.sv -----
`timescale 1ns / 1ps

module flic_chunk_decoder_unit_tb;

  localparam int unsigned StallLimit = 4000;

  typedef enum int {
    PH_IDLE, PH_HDR, PH_PAD,
    PH_SS2_LINES, PH_SS2_CTRL, PH_SS2_SKIP, PH_SS2_CNT, PH_SS2_REP, PH_SS2_LIT,
    PH_LC_SKIPL, PH_LC_LINES, PH_LC_PKTS, PH_LC_SKIP, PH_LC_CNT, PH_LC_REP, PH_LC_LIT,
    PH_BR_PKTS, PH_BR_CNT, PH_BR_REP, PH_BR_LIT,
    PH_COPY,
    PH_PAL_PKTS, PH_PAL_SKIP, PH_PAL_CNT, PH_PAL_DATA
  } parse_phase_e;

  class write_run_predictor;
    int unsigned  width_reg, height_reg;
    parse_phase_e phase;
    int unsigned  bytes_left, kind, chunks_left, lines_left, pkts_left;
    int unsigned  line_base, wptr, run_left, field_acc, pal_idx, slot;
    int unsigned  step_writes, errors, checked;
    flicd_pkg::out_item_t expected_writes[$];

    function void reset_state();
      width_reg = 320; height_reg = 200; phase = PH_IDLE;
      bytes_left = 0; kind = 0; chunks_left = 0; lines_left = 0; pkts_left = 0;
      line_base = 0; wptr = 0; run_left = 0; field_acc = 0; pal_idx = 0; slot = 0;
      expected_writes.delete();
    endfunction

    function void set_reg(logic [7:0] idx, logic [10:0] v);
      if (idx == flicd_pkg::REG_WIDTH) width_reg = v;
      else if (idx == flicd_pkg::REG_HEIGHT) height_reg = v;
    endfunction

    function int unsigned ew();
      return width_reg < 1 ? 1 : (width_reg > flicd_pkg::MaxWidth ? flicd_pkg::MaxWidth
                                                                  : width_reg);
    endfunction

    function int unsigned eh();
      return height_reg < 1 ? 1 : (height_reg > flicd_pkg::MaxHeight ? flicd_pkg::MaxHeight
                                                                     : height_reg);
    endfunction

    function int unsigned fsize();
      return ew() * eh();
    endfunction

    function int unsigned padd(int unsigned p, longint unsigned d);
      longint unsigned r;
      r = longint'(p) + d;
      return r > fsize() ? fsize() : int'(r);
    endfunction

    function void emit(flicd_pkg::write_kind_e k, int unsigned a, int unsigned len,
                       int unsigned v, bit fend);
      flicd_pkg::out_item_t o;
      if (step_writes >= 2) return;
      o.write_kind    = k;
      o.write_address = a[19:0];
      o.run_length    = len[20:0];
      o.write_value   = v[15:0];
      o.frame_end     = fend;
      expected_writes.push_back(o);
      step_writes++;
    endfunction

    function void pixel_run(flicd_pkg::write_kind_e k, int unsigned a, int unsigned len,
                            int unsigned v);
      int unsigned room;
      if (a >= fsize()) return;
      room = fsize() - a;
      if (k == flicd_pkg::WK_WORD) room = room / 2;
      if (len > room) len = room;
      if (len == 0) return;
      emit(k, a, len, v, 1'b0);
    endfunction

    function bit take_word(int unsigned b, output int unsigned w);
      w = 0;
      if (slot == 0) begin
        field_acc = b; slot = 1;
        return 1'b0;
      end
      w = (field_acc & 8'hFF) | (b << 8);
      slot = 0;
      return 1'b1;
    endfunction

    function void line_done(parse_phase_e nxt);
      line_base = padd(line_base, ew());
      wptr = line_base;
      if (lines_left > 0) lines_left--;
      phase = lines_left == 0 ? PH_PAD : nxt;
    endfunction

    function void packet_done(parse_phase_e nxt_pkt, parse_phase_e nxt_line);
      if (pkts_left > 0) pkts_left--;
      if (pkts_left == 0) line_done(nxt_line);
      else phase = nxt_pkt;
    endfunction

    function void literal_byte(int unsigned b, parse_phase_e nxt_pkt,
                               parse_phase_e nxt_line);
      pixel_run(flicd_pkg::WK_BYTE, wptr, 1, b);
      wptr = padd(wptr, 1);
      if (run_left > 0) run_left--;
      if (run_left == 0) packet_done(nxt_pkt, nxt_line);
    endfunction

    function void body_byte(int unsigned b);
      int unsigned w;
      w = 0;
      case (phase)
        PH_SS2_LINES: if (take_word(b, w)) begin
          lines_left = w; phase = w != 0 ? PH_SS2_CTRL : PH_PAD;
        end
        PH_SS2_CTRL: if (take_word(b, w)) begin
          if (w & 16'h8000) begin
            wptr = padd(wptr, longint'(ew()) * (65536 - w));
          end else begin
            pkts_left = w > eh() ? 0 : w;
            line_base = wptr;
            if (pkts_left == 0) line_done(PH_SS2_CTRL);
            else phase = PH_SS2_SKIP;
          end
        end
        PH_SS2_SKIP: begin
          wptr = padd(wptr, b); phase = PH_SS2_CNT;
        end
        PH_SS2_CNT: begin
          if (b & 8'h80) begin
            run_left = 256 - b; phase = PH_SS2_REP;
          end else if (b == 0) begin
            packet_done(PH_SS2_SKIP, PH_SS2_CTRL);
          end else begin
            run_left = 2 * b; phase = PH_SS2_LIT;
          end
        end
        PH_SS2_REP: if (take_word(b, w)) begin
          pixel_run(flicd_pkg::WK_WORD, wptr, run_left, w);
          wptr = padd(wptr, 2 * longint'(run_left));
          packet_done(PH_SS2_SKIP, PH_SS2_CTRL);
        end
        PH_SS2_LIT: literal_byte(b, PH_SS2_SKIP, PH_SS2_CTRL);
        PH_LC_SKIPL: if (take_word(b, w)) begin
          line_base = padd(0, longint'(w) * ew());
          wptr = line_base; phase = PH_LC_LINES;
        end
        PH_LC_LINES: if (take_word(b, w)) begin
          lines_left = w; phase = w != 0 ? PH_LC_PKTS : PH_PAD;
        end
        PH_LC_PKTS: begin
          pkts_left = b;
          if (b == 0) line_done(PH_LC_PKTS);
          else phase = PH_LC_SKIP;
        end
        PH_LC_SKIP: begin
          wptr = padd(wptr, b); phase = PH_LC_CNT;
        end
        PH_LC_CNT: begin
          if (b & 8'h80) begin
            run_left = 256 - b; phase = PH_LC_REP;
          end else if (b == 0) begin
            packet_done(PH_LC_SKIP, PH_LC_PKTS);
          end else begin
            run_left = b; phase = PH_LC_LIT;
          end
        end
        PH_LC_REP: begin
          pixel_run(flicd_pkg::WK_BYTE, wptr, run_left, b);
          wptr = padd(wptr, run_left);
          packet_done(PH_LC_SKIP, PH_LC_PKTS);
        end
        PH_LC_LIT: literal_byte(b, PH_LC_SKIP, PH_LC_PKTS);
        PH_BR_PKTS: begin
          pkts_left = b;
          if (b == 0) line_done(PH_BR_PKTS);
          else phase = PH_BR_CNT;
        end
        PH_BR_CNT: begin
          if (b & 8'h80) begin
            run_left = 256 - b; phase = PH_BR_LIT;
          end else begin
            run_left = b; phase = PH_BR_REP;
          end
        end
        PH_BR_REP: begin
          pixel_run(flicd_pkg::WK_BYTE, wptr, run_left, b);
          wptr = padd(wptr, run_left);
          packet_done(PH_BR_CNT, PH_BR_PKTS);
        end
        PH_BR_LIT: literal_byte(b, PH_BR_CNT, PH_BR_PKTS);
        PH_COPY: begin
          pixel_run(flicd_pkg::WK_BYTE, wptr, 1, b);
          wptr = padd(wptr, 1);
          if (wptr >= fsize()) phase = PH_PAD;
        end
        PH_PAL_PKTS: if (take_word(b, w)) begin
          pkts_left = w; pal_idx = 0;
          phase = w != 0 ? PH_PAL_SKIP : PH_PAD;
        end
        PH_PAL_SKIP: begin
          pal_idx += b;
          if (pal_idx > flicd_pkg::PaletteEntries) pal_idx = flicd_pkg::PaletteEntries;
          phase = PH_PAL_CNT;
        end
        PH_PAL_CNT: begin
          run_left = b != 0 ? b : 256;
          slot = 0; phase = PH_PAL_DATA;
        end
        PH_PAL_DATA: begin
          w = kind == flicd_pkg::CK_PAL6 ? ((b << 2) & 8'hFF) : b;
          if (pal_idx < flicd_pkg::PaletteEntries)
            emit(flicd_pkg::WK_PAL, pal_idx * 3 + slot, 1, w, 1'b0);
          slot++;
          if (slot >= 3) begin
            slot = 0;
            if (pal_idx < flicd_pkg::PaletteEntries) pal_idx++;
            if (run_left > 0) run_left--;
            if (run_left == 0) begin
              if (pkts_left > 0) pkts_left--;
              phase = pkts_left != 0 ? PH_PAL_SKIP : PH_PAD;
            end
          end
        end
        default: ;
      endcase
    endfunction

    function bit header_byte(int unsigned b);
      if (slot == 0) field_acc = b;
      else if (slot < 4) field_acc |= b << (8 * slot);
      else if (slot == 4) kind = b;
      else kind = (kind | (b << 8)) & 16'hFFFF;
      slot++;
      if (slot < 6) return 1'b0;
      slot = 0; wptr = 0; line_base = 0; lines_left = 0; pkts_left = 0; run_left = 0;
      if (kind == flicd_pkg::CK_SS2) phase = PH_SS2_LINES;
      else if (kind == flicd_pkg::CK_LC) phase = PH_LC_SKIPL;
      else if (kind == flicd_pkg::CK_BRUN) begin
        lines_left = eh(); phase = PH_BR_PKTS;
      end else if (kind == flicd_pkg::CK_COPY) phase = PH_COPY;
      else if (kind == flicd_pkg::CK_BLACK) begin
        pixel_run(flicd_pkg::WK_BYTE, 0, fsize(), 0); phase = PH_PAD;
      end else if (kind == flicd_pkg::CK_PAL8 || kind == flicd_pkg::CK_PAL6) begin
        phase = PH_PAL_PKTS;
      end else phase = PH_PAD;
      bytes_left = field_acc > 6 ? field_acc - 6 : 0;
      return bytes_left == 0;
    endfunction

    function void note_byte(flicd_pkg::in_item_t it);
      bit over;
      step_writes = 0;
      if (it.frame_start) begin
        chunks_left = it.chunk_count; phase = PH_HDR; slot = 0; field_acc = 0;
        if (chunks_left == 0) begin
          phase = PH_IDLE;
          emit(flicd_pkg::WK_END, 0, 0, 0, 1'b1);
          return;
        end
      end
      if (phase == PH_IDLE) return;
      if (phase == PH_HDR) begin
        over = header_byte(it.data_byte);
      end else begin
        if (bytes_left > 0) bytes_left--;
        body_byte(it.data_byte);
        over = bytes_left == 0;
      end
      if (over) begin
        if (chunks_left > 0) chunks_left--;
        phase = PH_HDR; slot = 0; field_acc = 0;
        if (chunks_left == 0) begin
          phase = PH_IDLE;
          emit(flicd_pkg::WK_END, 0, 0, 0, 1'b1);
        end
      end
    endfunction

    function void check_result(flicd_pkg::out_item_t got);
      flicd_pkg::out_item_t exp;
      checked++;
      if (expected_writes.size() == 0) begin
        $error("unexpected transaction kind %0d addr %0d", got.write_kind, got.write_address);
        errors++;
        return;
      end
      exp = expected_writes.pop_front();
      if (got.write_kind !== exp.write_kind) begin
        $error("write_kind expected %0d got %0d", exp.write_kind, got.write_kind); errors++;
      end
      if (got.write_address !== exp.write_address) begin
        $error("write_address expected %0d got %0d", exp.write_address, got.write_address);
        errors++;
      end
      if (got.run_length !== exp.run_length) begin
        $error("run_length expected %0d got %0d", exp.run_length, got.run_length); errors++;
      end
      if (got.write_value !== exp.write_value) begin
        $error("write_value expected %0h got %0h", exp.write_value, got.write_value); errors++;
      end
      if (got.frame_end !== exp.frame_end) begin
        $error("frame_end expected %0d got %0d", exp.frame_end, got.frame_end); errors++;
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        in_valid_i, in_ready_o, out_valid_o, out_ready_i, cfg_valid_i, cfg_ready_o;
  flicd_pkg::in_item_t  in_data_i;
  flicd_pkg::out_item_t out_data_o;
  logic [7:0]  cfg_index_i;
  logic [10:0] cfg_data_i;

  write_run_predictor model = new;
  byte unsigned chunk_body[$];
  byte unsigned frame_bytes[$];
  bit          quiet;
  int unsigned bytes_sent, stall_cycles, out_hold, settings_run;

  flic_chunk_decoder_unit dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) model.note_byte(in_data_i);
      if (out_valid_o && out_ready_i) model.check_result(out_data_o);
      if (cfg_valid_i && cfg_ready_o) model.set_reg(cfg_index_i, cfg_data_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
          (cfg_valid_i && cfg_ready_o)) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
      if (stall_cycles > StallLimit) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  always @(posedge clk_i) begin
    if (quiet || !rst_ni) begin
      out_ready_i <= 1'b1; out_hold <= 0;
    end else if (out_hold > 0) begin
      out_ready_i <= 1'b0; out_hold <= out_hold - 1;
    end else if ($urandom_range(0, 5) == 0) begin
      out_ready_i <= 1'b0; out_hold <= $urandom_range(0, 7);
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  task automatic send_item(flicd_pkg::in_item_t it);
    bit acc;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    do begin
      @(negedge clk_i);
      acc = in_ready_o;
      @(posedge clk_i);
    end while (!acc);
    bytes_sent++;
  endtask

  task automatic send_frame(int unsigned cc);
    flicd_pkg::in_item_t it;
    foreach (frame_bytes[i]) begin
      it.data_byte   = frame_bytes[i];
      it.frame_start = (i == 0);
      it.chunk_count = i == 0 ? cc[15:0] : 16'($urandom);
      send_item(it);
    end
    frame_bytes.delete();
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (model.expected_writes.size() != 0) @(posedge clk_i);
    repeat (5) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [7:0] idx, logic [10:0] v);
    bit acc;
    cfg_valid_i <= 1'b1; cfg_index_i <= idx; cfg_data_i <= v;
    do begin
      @(negedge clk_i);
      acc = cfg_ready_o;
      @(posedge clk_i);
    end while (!acc);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic void push16(int unsigned v);
    chunk_body.push_back(v[7:0]);
    chunk_body.push_back(v[15:8]);
  endfunction

  function automatic void push_rand(int unsigned n);
    repeat (n) chunk_body.push_back(8'($urandom));
  endfunction

  function automatic void add_chunk(int unsigned ctype, int unsigned size);
    frame_bytes.push_back(size[7:0]);   frame_bytes.push_back(size[15:8]);
    frame_bytes.push_back(size[23:16]); frame_bytes.push_back(size[31:24]);
    frame_bytes.push_back(ctype[7:0]);  frame_bytes.push_back(ctype[15:8]);
    foreach (chunk_body[i]) frame_bytes.push_back(chunk_body[i]);
    chunk_body.delete();
  endfunction

  // mostly well-formed chunk bodies with random content
  function automatic void gen_chunk();
    int unsigned ctype, n, size, sel;
    sel = $urandom_range(0, 8);
    case (sel)
      0: begin
        ctype = flicd_pkg::CK_SS2;
        n = $urandom_range(0, 3);
        push16(n);
        repeat (n) begin
          if ($urandom_range(0, 3) == 0) push16(65536 - $urandom_range(1, 3));
          push16($urandom_range(0, 9) == 0 ? $urandom : $urandom_range(0, 3));
          repeat ($urandom_range(0, 3)) begin
            chunk_body.push_back(8'($urandom_range(0, 20)));
            case ($urandom_range(0, 4))
              0: chunk_body.push_back(8'd0);
              1, 2: begin
                chunk_body.push_back(8'(256 - $urandom_range(1, 128))); push_rand(2);
              end
              default: begin
                n = $urandom_range(1, 3); chunk_body.push_back(8'(n)); push_rand(2 * n);
              end
            endcase
          end
        end
      end
      1: begin
        ctype = flicd_pkg::CK_LC;
        push16($urandom_range(0, 4) == 0 ? $urandom : $urandom_range(0, 3));
        n = $urandom_range(0, 3);
        push16(n);
        repeat (n) begin
          chunk_body.push_back(8'($urandom_range(0, 3)));
          repeat ($urandom_range(0, 3)) begin
            chunk_body.push_back(8'($urandom_range(0, 30)));
            case ($urandom_range(0, 4))
              0: chunk_body.push_back(8'd0);
              1, 2: begin
                chunk_body.push_back(8'(256 - $urandom_range(1, 128))); push_rand(1);
              end
              default: begin
                n = $urandom_range(1, 4); chunk_body.push_back(8'(n)); push_rand(n);
              end
            endcase
          end
        end
      end
      2: begin
        ctype = flicd_pkg::CK_BRUN;
        repeat ($urandom_range(1, 3)) begin
          chunk_body.push_back(8'($urandom_range(0, 3)));
          repeat ($urandom_range(0, 3)) begin
            if ($urandom_range(0, 1)) begin
              chunk_body.push_back(8'($urandom_range(0, 127))); push_rand(1);
            end else begin
              n = $urandom_range(1, 4);
              chunk_body.push_back(8'(256 - n)); push_rand(n);
            end
          end
        end
      end
      3: begin
        ctype = flicd_pkg::CK_COPY; push_rand($urandom_range(0, 20));
      end
      4: ctype = flicd_pkg::CK_BLACK;
      5, 6: begin
        ctype = $urandom_range(0, 1) ? flicd_pkg::CK_PAL6 : flicd_pkg::CK_PAL8;
        n = $urandom_range(0, 2);
        push16(n);
        repeat (n) begin
          chunk_body.push_back(8'($urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 8)));
          n = $urandom_range(0, 12) == 0 ? 0 : $urandom_range(1, 3);
          chunk_body.push_back(8'(n));
          push_rand(3 * (n == 0 ? 256 : n));
        end
      end
      default: begin
        ctype = $urandom_range(0, 1) ? 3 : $urandom_range(256, 65535);
        push_rand($urandom_range(0, 5));
      end
    endcase
    sel = $urandom_range(0, 19);
    if (sel == 0) size = $urandom_range(0, 5);
    else if (sel < 3) size = 6 + $urandom_range(0, chunk_body.size());
    else size = 6 + chunk_body.size() + $urandom_range(0, 2);
    if (sel == 0) chunk_body.delete();
    while (chunk_body.size() + 6 < size) chunk_body.push_back(8'($urandom));
    while (chunk_body.size() + 6 > size && size >= 6) void'(chunk_body.pop_back());
    add_chunk(ctype, size);
  endfunction

  task automatic random_frames(int unsigned target);
    int unsigned nch, cc, sel;
    while (bytes_sent < target) begin
      nch = $urandom_range(1, 3);
      repeat (nch) gen_chunk();
      sel = $urandom_range(0, 19);
      if (sel == 0) cc = 0;
      else if (sel == 1) cc = nch + 1;
      else if (sel == 2) cc = nch - 1;
      else if (sel == 3) cc = 16'hFFFF;
      else cc = nch;
      if (cc == 0) begin
        frame_bytes.delete(); frame_bytes.push_back(8'($urandom));
      end
      send_frame(cc);
    end
  endtask

  initial begin
    flicd_pkg::in_item_t stray;
    int unsigned widths[6];
    int unsigned heights[6];
    widths  = '{16, 0, 2047, 1, 37, 1024};
    heights = '{8, 0, 2047, 5, 3, 1024};
    quiet = 1'b0;
    rst_ni = 1'b0;
    in_valid_i = 1'b0; in_data_i = '0;
    cfg_valid_i = 1'b0; cfg_index_i = '0; cfg_data_i = '0;
    bytes_sent = 0; settings_run = 1;
    model.reset_state();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // bytes before any frame are ignored
    stray = '{data_byte: 8'hFF, frame_start: 1'b0, chunk_count: 16'hFFFF};
    send_item(stray);
    add_chunk(flicd_pkg::CK_BLACK, 6);
    send_frame(1);
    frame_bytes.push_back(8'hA5);
    send_frame(0);
    add_chunk(16'hFFFF, 0);
    send_frame(1);
    random_frames(100);
    drain();

    foreach (widths[i]) begin
      write_reg(flicd_pkg::REG_WIDTH, widths[i][10:0]);
      write_reg(flicd_pkg::REG_HEIGHT, heights[i][10:0]);
      settings_run++;
      if (i == 5) quiet = 1'b1;
      random_frames(100 * (i + 2));
      drain();
    end

    $display("decoded %0d chunk bytes into %0d checked writes across %0d frame geometries",
             bytes_sent, model.checked, settings_run);
    if (model.errors == 0 && model.expected_writes.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
